@@ rtl/imu_complementary_tilt_filter_unit_macros.svh @@
// Assertion macros for the tilt filter block.
// Used by modules that check their own control sequencing; needs clk and rst_n in scope.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_UNIT_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ICTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define ICTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ictf_pkg.sv @@
// Shared types, constants and helper functions of the tilt filter block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ictf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int ATAN_TAB_LEN    = 24;
    localparam int STEPS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
    localparam int STEP_IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam int ANGLE_W = 32;
    // CORDIC datapath width, covers the gain growth of x
    localparam int CX_W = 34;
    localparam int TILT_SCALE_SH = 14;
    // Square root radicand: sum of squares shifted left by 28
    localparam int RAD_SHIFT = 28;
    localparam int RAD_W = 60;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SQ_K_W = $clog2(SQRT_STEPS);

    // Gyro increment: |v| * dt * 2^F / RATE_DEN, rounded
    localparam int RATE_DEN  = 33536000;
    localparam int RATE_HALF = RATE_DEN / 2;
    localparam int V_W = 25;
    localparam int MAG_W = 57;
    localparam int NUM_W = MAG_W + ANGLE_FRAC_BITS;
    // RATE_DEN = 2^11 * DIV_K, DIV_K = 2^14 - 9
    localparam int DIV_PRE_SH = 11;
    localparam int DIV_K = 16375;
    localparam int DIV_K_SH = 14;
    localparam int REM_W = NUM_W - DIV_PRE_SH;
    localparam int QUO_W = REM_W - DIV_K_SH + 1;
    localparam int DELTA_W = QUO_W + 1;
    localparam int SAT_IN_W = DELTA_W + 1;

    localparam int W_ONE = 65536;
    localparam int BLEND_W = 51;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X     = 3'd0,
        REG_OFFSET_Y     = 3'd1,
        REG_OFFSET_Z     = 3'd2,
        REG_MIN_INTERVAL = 3'd3,
        REG_GYRO_WEIGHT  = 3'd4
    } cfg_index_t;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [29:0] ATAN_Q24 [ATAN_TAB_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
        30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
        30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
        30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229, 30'd115
    };

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [31:0]        time_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] roll_deg;
        logic signed [31:0] pitch_deg;
        logic signed [31:0] yaw_deg;
        logic               updated;
    } out_item_t;

    // Classified sample handed from front to back
    typedef struct packed {
        in_item_t    item;
        logic [31:0] dt;
        logic        upd;
    } q_entry_t;

    typedef struct packed {
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
        logic [7:0]         min_interval_ms;
        logic [16:0]        gyro_weight;
    } cfg_t;

    typedef enum logic [2:0] {
        B_IDLE, B_MUL, B_DINIT, B_DIV, B_WAIT, B_BLEND1, B_BLEND2, B_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        T_IDLE, T_SQRT, T_CORDIC
    } tilt_state_t;

    // Rotation angle of step i in the angle format
    function automatic logic signed [ANGLE_W-1:0] step_angle(input logic [STEP_IDX_W-1:0] i);
        logic [39:0] t;
        t = {10'b0, ATAN_Q24[i]};
        if (ANGLE_FRAC_BITS < 24)
            t = (t + (40'd1 << (23 - ANGLE_FRAC_BITS))) >> (24 - ANGLE_FRAC_BITS);
        else
            t = t << (ANGLE_FRAC_BITS - 24);
        return $signed(t[ANGLE_W-1:0]);
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(32'sh7FFFFFFF);
        lo = SAT_IN_W'(32'sh80000000);
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        return v[ANGLE_W-1:0];
    endfunction

endpackage

@@ rtl/imu_complementary_tilt_filter_unit.sv @@
// Top level of the IMU complementary tilt filter: config registers, front, queue, back.
// Depends on ictf_pkg, ictf_front, ictf_queue, ictf_back.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+------------------------
//  input   | in_valid, in_ready, in_data      | in_valid && in_ready
//  output  | out_valid, out_ready, out_data   | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
// A skipped sample passes the queue and the back end's idle and output states to out_valid; an
// updating sample also waits for the tilt units (30 square root steps, 16 CORDIC steps).
// The gyro divisions (shift, fold, one compare and subtract) run alongside.
// Reset: angles and last update time zero, offsets 0, interval 3, weight 64225.
// A two-entry queue lets input transfers continue while the back end or output stalls.
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ictf_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ictf_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [ictf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ictf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ictf_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     push_valid, push_ready, pop_valid, pop_ready;
    q_entry_t push_data, pop_data;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X:     cfg_next.offset_x = $signed(cfg_wdata);
                REG_OFFSET_Y:     cfg_next.offset_y = $signed(cfg_wdata);
                REG_OFFSET_Z:     cfg_next.offset_z = $signed(cfg_wdata);
                REG_MIN_INTERVAL: cfg_next.min_interval_ms = cfg_wdata[7:0];
                REG_GYRO_WEIGHT:  cfg_next.gyro_weight = cfg_wdata[16:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
            cfg_reg.min_interval_ms <= 8'd3;
            cfg_reg.gyro_weight <= 17'd64225;
        end
        else
            cfg_reg <= cfg_next;
    end

    ictf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .min_interval_ms (cfg_reg.min_interval_ms),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    ictf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ictf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/ictf_front.sv @@
// Front end: accepts samples, checks the update interval, tracks last update time.
// Depends on ictf_pkg.
`timescale 1ns / 1ps

module ictf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ictf_pkg::in_item_t in_data,
    input  logic [7:0]         min_interval_ms,
    output logic               push_valid,
    input  logic               push_ready,
    output ictf_pkg::q_entry_t push_data
);
    import ictf_pkg::*;

    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] dt;
    logic        upd;

    // Classify the sample against the last update time
    always_comb
    begin
        dt = in_data.time_ms - last_time_reg;
        upd = (dt >= 32'(min_interval_ms));
        in_ready = push_ready;
        push_valid = in_valid;
        push_data.item = in_data;
        push_data.dt = dt;
        push_data.upd = upd;
        last_time_next = last_time_reg;
        if (in_valid && push_ready && upd)
            last_time_next = in_data.time_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_time_reg <= '0;
        else
            last_time_reg <= last_time_next;
    end

endmodule

@@ rtl/ictf_queue.sv @@
// Short FIFO between the front end and the compute back end.
// Depends on ictf_pkg.
`timescale 1ns / 1ps

module ictf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ictf_pkg::q_entry_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ictf_pkg::q_entry_t pop_data
);
    import ictf_pkg::*;

    q_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    always_comb
    begin
        push_ready = (count_reg != QCNT_W'(QDEPTH));
        pop_valid = (count_reg != '0);
        pop_data = mem[rd_ptr_reg];
        do_push = push_valid && push_ready;
        do_pop = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    // Storage, payload only
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/ictf_tilt.sv @@
// Tilt angle unit: atan2(num, sqrt(a^2 + b^2)) in degrees.
// Bit-pair square root then vectoring CORDIC, one step per cycle. Depends on ictf_pkg.
`timescale 1ns / 1ps

module ictf_tilt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [16:0]  num,
    input  logic signed [15:0]  a,
    input  logic signed [15:0]  b,
    output logic                busy,
    output logic signed [31:0]  angle
);
    import ictf_pkg::*;

    tilt_state_t              state_reg, state_next;
    logic [RAD_W-1:0]         n_reg, n_next;
    logic [RAD_W-1:0]         res_reg, res_next;
    logic [SQ_K_W-1:0]        k_reg, k_next;
    logic [STEP_IDX_W-1:0]    i_reg, i_next;
    logic signed [CX_W-1:0]   x_reg, x_next;
    logic signed [CX_W-1:0]   y_reg, y_next;
    logic signed [ANGLE_W-1:0] z_reg, z_next;

    logic [31:0]              sum_sq;
    logic [RAD_W-1:0]         sq_bit, trial;
    logic signed [CX_W-1:0]   dx, dy;
    logic signed [ANGLE_W-1:0] sa;

    always_comb
    begin
        sum_sq = unsigned'(32'(a) * 32'(a)) + unsigned'(32'(b) * 32'(b));
        sq_bit = RAD_W'(1) << {k_reg, 1'b0};
        trial = res_reg + sq_bit;
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        sa = step_angle(i_reg);

        state_next = state_reg;
        n_next = n_reg;
        res_next = res_reg;
        k_next = k_reg;
        i_next = i_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;

        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    n_next = {sum_sq, RAD_SHIFT'(0)};
                    res_next = '0;
                    k_next = SQ_K_W'(SQRT_STEPS - 1);
                    y_next = CX_W'(num) <<< TILT_SCALE_SH;
                    z_next = '0;
                    state_next = T_SQRT;
                end
            end
            // one result bit per cycle
            T_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    res_next = (res_reg >> 1) + sq_bit;
                end
                else
                    res_next = res_reg >> 1;
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    x_next = $signed({1'b0, res_next[CX_W-2:0]});
                    i_next = '0;
                    state_next = T_CORDIC;
                end
            end
            // vectoring step; y at zero leaves x, y and z alone
            T_CORDIC:
            begin
                if (!y_reg[CX_W-1] && (y_reg != '0))
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + sa;
                end
                else if (y_reg[CX_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - sa;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == STEP_IDX_W'(STEPS - 1))
                    state_next = T_IDLE;
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    assign busy = (state_reg != T_IDLE);
    assign angle = z_reg;

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        res_reg <= res_next;
        k_reg <= k_next;
        i_reg <= i_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            z_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            z_reg <= z_next;
        end
    end

endmodule

@@ rtl/ictf_back.sv @@
// Back end: gyro increments (constant division by shift and fold), tilt angles, blend,
// output register. Depends on ictf_pkg, ictf_tilt and the assertion macro header.
`timescale 1ns / 1ps

module ictf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ictf_pkg::cfg_t      cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  ictf_pkg::q_entry_t  pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ictf_pkg::out_item_t out_data
);
    import ictf_pkg::*;
    `include "imu_complementary_tilt_filter_unit_macros.svh"

    back_state_t              state_reg, state_next;
    q_entry_t                 job_reg, job_next;
    logic signed [ANGLE_W-1:0] roll_reg, roll_next;
    logic signed [ANGLE_W-1:0] pitch_reg, pitch_next;
    logic signed [ANGLE_W-1:0] yaw_reg, yaw_next;
    logic [MAG_W-1:0]         mag_reg [3];
    logic [MAG_W-1:0]         mag_next [3];
    logic                     neg_reg [3];
    logic                     neg_next [3];
    logic [QUO_W-1:0]         quo_reg [3];
    logic [QUO_W-1:0]         quo_next [3];
    logic [REM_W-1:0]         rem_reg [3];
    logic [REM_W-1:0]         rem_next [3];
    logic signed [49:0]       pg_reg [2];
    logic signed [49:0]       pg_next [2];
    logic signed [49:0]       pa_reg [2];
    logic signed [49:0]       pa_next [2];
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg, out_next;

    logic                     roll_busy, pitch_busy, tilt_start;
    logic signed [ANGLE_W-1:0] roll_tilt, pitch_tilt;
    logic signed [15:0]       raw [3];
    logic signed [23:0]       off [3];
    logic signed [V_W-1:0]    v [3];
    logic [V_W-1:0]           vmag [3];
    logic [NUM_W-1:0]         numer [3];
    logic [REM_W-DIV_K_SH-1:0] tq [3];
    logic [REM_W-1:0]         fold [3];
    logic                     div_more, div_done;
    logic signed [DELTA_W-1:0] delta [3];
    logic signed [ANGLE_W-1:0] g [2];
    logic signed [ANGLE_W-1:0] acc [2];
    logic signed [ANGLE_W-1:0] prev [2];
    logic signed [17:0]       w_s, aw_s;
    logic signed [BLEND_W-1:0] bsum [2];
    logic signed [ANGLE_W-1:0] bres [2];
    logic                     out_load;

    ictf_tilt u_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tilt_start),
        .num   (17'(job_reg.item.accel_y)),
        .a     (job_reg.item.accel_x),
        .b     (job_reg.item.accel_z),
        .busy  (roll_busy),
        .angle (roll_tilt)
    );

    ictf_tilt u_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tilt_start),
        .num   (-17'(job_reg.item.accel_x)),
        .a     (job_reg.item.accel_y),
        .b     (job_reg.item.accel_z),
        .busy  (pitch_busy),
        .angle (pitch_tilt)
    );

    always_comb
    begin
        raw[0] = job_reg.item.rate_x;
        raw[1] = job_reg.item.rate_y;
        raw[2] = job_reg.item.rate_z;
        off[0] = cfg.offset_x;
        off[1] = cfg.offset_y;
        off[2] = cfg.offset_z;
        acc[0] = roll_tilt;
        acc[1] = pitch_tilt;
        prev[0] = roll_reg;
        prev[1] = pitch_reg;
        // weight above one acts as one
        w_s = (cfg.gyro_weight > 17'(W_ONE)) ? 18'sd65536 : $signed({1'b0, cfg.gyro_weight});
        aw_s = 18'sd65536 - w_s;
        tilt_start = (state_reg == B_MUL);
        pop_ready = (state_reg == B_IDLE);
        out_load = !out_valid_reg || out_ready;

        state_next = state_reg;
        job_next = job_reg;
        roll_next = roll_reg;
        pitch_next = pitch_reg;
        yaw_next = yaw_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        div_more = 1'b0;
        div_done = 1'b1;

        for (int l = 0; l < 3; l++)
        begin
            v[l] = (V_W'(raw[l]) <<< 8) + V_W'(off[l]);
            vmag[l] = v[l][V_W-1] ? V_W'(-v[l]) : V_W'(v[l]);
            numer[l] = {mag_reg[l], ANGLE_FRAC_BITS'(0)} + NUM_W'(RATE_HALF);
            // r = hi * 2^14 + lo  ->  hi * DIV_K + (lo + 9 * hi)
            tq[l] = rem_reg[l][REM_W-1:DIV_K_SH];
            fold[l] = REM_W'(rem_reg[l][DIV_K_SH-1:0]) + (REM_W'(tq[l]) << 3) + REM_W'(tq[l]);
            div_more = div_more | (tq[l] != '0);
            div_done = div_done & (rem_reg[l] < REM_W'(DIV_K));
            delta[l] = neg_reg[l] ? -$signed({1'b0, quo_reg[l]}) : $signed({1'b0, quo_reg[l]});
            mag_next[l] = mag_reg[l];
            neg_next[l] = neg_reg[l];
            quo_next[l] = quo_reg[l];
            rem_next[l] = rem_reg[l];
        end

        for (int l = 0; l < 2; l++)
        begin
            g[l] = sat_angle(SAT_IN_W'(prev[l]) + SAT_IN_W'(delta[l]));
            pg_next[l] = pg_reg[l];
            pa_next[l] = pa_reg[l];
            bsum[l] = BLEND_W'(pg_reg[l]) + BLEND_W'(pa_reg[l]) + BLEND_W'(32768);
            bres[l] = sat_angle(SAT_IN_W'(bsum[l] >>> 16));
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    job_next = pop_data;
                    state_next = pop_data.upd ? B_MUL : B_OUT;
                end
            end
            // rate magnitudes times elapsed time; tilt units start
            B_MUL:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    mag_next[l] = MAG_W'(vmag[l]) * MAG_W'(job_reg.dt);
                    neg_next[l] = v[l][V_W-1];
                end
                state_next = B_DINIT;
            end
            // rounded numerator, power-of-two part of the divisor shifted out
            B_DINIT:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_next[l] = numer[l][NUM_W-1:DIV_PRE_SH];
                    quo_next[l] = '0;
                end
                state_next = B_DIV;
            end
            // fold the remainder until it is below 2^14, then one compare and subtract
            B_DIV:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (tq[l] != '0)
                    begin
                        rem_next[l] = fold[l];
                        quo_next[l] = quo_reg[l] + QUO_W'(tq[l]);
                    end
                    else if (rem_reg[l] >= REM_W'(DIV_K))
                    begin
                        rem_next[l] = rem_reg[l] - REM_W'(DIV_K);
                        quo_next[l] = quo_reg[l] + 1'b1;
                    end
                end
                if (!div_more)
                    state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (!roll_busy && !pitch_busy)
                    state_next = B_BLEND1;
            end
            // weighted products; yaw integrates directly
            B_BLEND1:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    pg_next[l] = w_s * g[l];
                    pa_next[l] = aw_s * acc[l];
                end
                yaw_next = sat_angle(SAT_IN_W'(yaw_reg) + SAT_IN_W'(delta[2]));
                state_next = B_BLEND2;
            end
            B_BLEND2:
            begin
                roll_next = bres[0];
                pitch_next = bres[1];
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    out_next.roll_deg = roll_reg;
                    out_next.pitch_deg = pitch_reg;
                    out_next.yaw_deg = yaw_reg;
                    out_next.updated = job_reg.upd;
                    out_valid_next = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
        for (int l = 0; l < 3; l++)
        begin
            mag_reg[l] <= mag_next[l];
            neg_reg[l] <= neg_next[l];
            quo_reg[l] <= quo_next[l];
            rem_reg[l] <= rem_next[l];
        end
        for (int l = 0; l < 2; l++)
        begin
            pg_reg[l] <= pg_next[l];
            pa_reg[l] <= pa_next[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            roll_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            roll_reg <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg <= yaw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ICTF_ASSERT_IMP(a_blend_after_tilt, state_reg == B_BLEND1, !roll_busy && !pitch_busy, "blend started with tilt unit busy")
    `ICTF_ASSERT_IMP(a_div_finished, state_reg == B_WAIT, div_done, "divider not finished at wait")
    `ICTF_ASSERT_NXT(a_skip_holds, (state_reg == B_IDLE) && pop_valid && !pop_data.upd, $stable(roll_reg) && $stable(pitch_reg) && $stable(yaw_reg), "skipped sample changed angles")

endmodule
